FILE: sv/mthz_pkg.sv
// Shared constants and codes for the multi-threshold hysteresis zoner.
package mthz_pkg;

   // Threshold register file layout
   localparam int THR_REGS   = 6;
   localparam int POINT_W    = 16;
   localparam int THR_W      = 3 * POINT_W;
   localparam int LOW_LSB    = 0;
   localparam int CENTER_LSB = POINT_W;
   localparam int HIGH_LSB   = 2 * POINT_W;

   // Zone and count widths
   localparam int ZONE_W  = 3;
   localparam int COUNT_W = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = THR_W;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_THRESHOLDS = 6;
   localparam int DEF_SAMPLE_WIDTH   = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR0  = 3'd1;

   // Item kinds
   typedef enum logic {
      KIND_FILTER = 1'b0,
      KIND_INIT   = 1'b1
   } kind_type;

endpackage

FILE: sv/multi_threshold_hysteresis_zoner.sv
// Multi-level hysteresis comparator: maps signed samples to zones 0..n, n the count clamped to 1..LIM.
// An accepted item waits in the input register, then loads the result register
// once that register is free or being emptied.
// Throughput: one item per cycle while rsp_ready holds; the zone memory is updated as an item
// moves to the result register, so the next item sees it at once.
// Reset: synchronous; clears both stages and the zone, sets the count to 1
// and all threshold points to zero.
module multi_threshold_hysteresis_zoner
   import mthz_pkg::*;
#(
   parameter int MAX_THRESHOLDS = DEF_MAX_THRESHOLDS,
   parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ZONE_W-1:0]              rsp_zone,
   input  logic                           csr_we,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata
);

   localparam int LIM   = (MAX_THRESHOLDS < THR_REGS) ? MAX_THRESHOLDS : THR_REGS;
   localparam int CMP_W = (SAMPLE_WIDTH > POINT_W) ? SAMPLE_WIDTH : POINT_W;
   localparam logic [COUNT_W-1:0] LIM_C = COUNT_W'(LIM);

   // Configuration registers
   logic [COUNT_W-1:0] count_ff;
   logic [THR_W-1:0]   thr_ff [THR_REGS];

   // Input stage
   logic                           in_valid_ff;
   logic                           in_kind_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;

   // Result stage and remembered zone
   logic              rsp_valid_ff;
   logic [ZONE_W-1:0] rsp_zone_ff;
   logic [ZONE_W-1:0] zone_ff;

   logic               advance;
   logic [COUNT_W-1:0] n_use;
   logic signed [CMP_W-1:0] s_ext;
   logic [THR_REGS-1:0] hit;
   logic [ZONE_W-1:0]   zone_in;

   // Handshake: input stage moves on when the result register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_zone  = rsp_zone_ff;

   // Write configuration registers; out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
         for (int i = 0; i < THR_REGS; i++) begin
            thr_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_COUNT) begin
            count_ff <= csr_wdata[COUNT_W-1:0];
         end
         for (int i = 0; i < THR_REGS; i++) begin
            if (csr_index == CSR_THR0 + CSR_IDX_W'(i)) begin
               thr_ff[i] <= csr_wdata[THR_W-1:0];
            end
         end
      end
   end

   // Clamp the count to 1..LIM
   always_comb begin
      n_use = count_ff;
      if (n_use == '0) begin
         n_use = COUNT_W'(1);
      end
      if (n_use > LIM_C) begin
         n_use = LIM_C;
      end
   end

   // Compare the sample against each threshold's chosen point
   assign s_ext = CMP_W'(in_sample_ff);

   always_comb begin
      logic signed [POINT_W-1:0] pt;
      for (int i = 0; i < THR_REGS; i++) begin
         if (in_kind_ff == KIND_INIT) begin
            pt = thr_ff[i][CENTER_LSB +: POINT_W];
         end else if (ZONE_W'(i) < zone_ff) begin
            pt = thr_ff[i][LOW_LSB +: POINT_W];
         end else begin
            pt = thr_ff[i][HIGH_LSB +: POINT_W];
         end
         hit[i] = (COUNT_W'(i) < n_use) && (s_ext < CMP_W'(pt));
      end
   end

   // Pick the first threshold hit, else the count
   always_comb begin
      zone_in = ZONE_W'(n_use);
      for (int i = THR_REGS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            zone_in = ZONE_W'(i);
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_kind_ff   <= req_kind;
         in_sample_ff <= req_sample;
      end
   end

   // Result register and zone memory
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         zone_ff      <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            zone_ff      <= zone_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_zone_ff <= zone_in;
      end
   end

endmodule

FILE: sv/mthz_checker.sv
// Port-level checks for the multi-threshold hysteresis zoner, bound to the top level.
module mthz_checker
   import mthz_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ZONE_W-1:0] rsp_zone
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_zone))
      else $error("stalled result changed or dropped");

   // Never show a zone beyond the threshold registers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_zone <= ZONE_W'(THR_REGS))
      else $error("zone out of range");

   // An empty result side means the input side is open
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with no result pending");

   // Reset leaves no result behind
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind multi_threshold_hysteresis_zoner mthz_checker u_mthz_checker (.*);
